// File: rtl/core/gcpr_pkg.sv
// Package for the gimbal command priority router.
// Holds the operation, origin and home status codes, register indexes and shared structs.
// No dependencies; every other file of the block refers to it by scoped names.
package gcpr_pkg;

  localparam int NUM_SRC   = 3;
  localparam int TIMEOUT_W = 10;
  localparam int ADDR_W    = 4;
  localparam int PDATA_W   = 32;

  localparam logic [TIMEOUT_W-1:0] MANUAL_TIMEOUT_RST   = 10'd17;
  localparam logic [TIMEOUT_W-1:0] VOICE_TIMEOUT_RST    = 10'd40;
  localparam logic [TIMEOUT_W-1:0] AUTONOMY_TIMEOUT_RST = 10'd12;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARRIVE = 2'd1,
    CMD_ESTOP  = 2'd2,
    CMD_HOME   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_MANUAL   = 2'd0,
    SRC_VOICE    = 2'd1,
    SRC_AUTONOMY = 2'd2,
    SRC_NONE     = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    ORG_ESTOP    = 3'd0,
    ORG_IDLE     = 3'd1,
    ORG_MANUAL   = 3'd2,
    ORG_VOICE    = 3'd3,
    ORG_AUTONOMY = 3'd4,
    ORG_HOME     = 3'd5
  } origin_t;

  typedef enum logic [2:0] {
    HOME_NONE        = 3'd0,
    HOME_ACCEPTED    = 3'd1,
    HOME_REJ_ESTOP   = 3'd2,
    HOME_REJ_MANUAL  = 3'd3,
    HOME_REJ_DRIVER  = 3'd4
  } home_t;

  typedef enum logic [1:0] {
    REG_MANUAL_TIMEOUT   = 2'd0,
    REG_VOICE_TIMEOUT    = 2'd1,
    REG_AUTONOMY_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] manual;
    logic [TIMEOUT_W-1:0] voice;
    logic [TIMEOUT_W-1:0] autonomy;
  } timeouts_t;

  typedef struct packed {
    cmd_t cmd;
    logic [1:0] source_id;
    logic yaw_hold;
    logic pitch_hold;
    logic estop_level;
    logic driver_ready;
  } item_ctrl_t;

  typedef struct packed {
    logic    publish;
    logic    yaw_hold;
    logic    pitch_hold;
    origin_t origin;
    home_t   home_status;
    logic    forward_home;
  } res_ctrl_t;

endpackage

// File: rtl/core/gcpr_cfg_regs.sv
// Configuration register file of the gimbal command priority router.
// Holds the three source timeouts behind an APB-style port; depends on gcpr_pkg.
module gcpr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gcpr_pkg::ADDR_W-1:0]      paddr,
  input  logic [gcpr_pkg::PDATA_W-1:0]     pwdata,
  output logic [gcpr_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output gcpr_pkg::timeouts_t              timeouts
);

  logic wr_en;
  gcpr_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = gcpr_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeouts.manual   <= gcpr_pkg::MANUAL_TIMEOUT_RST;
      timeouts.voice    <= gcpr_pkg::VOICE_TIMEOUT_RST;
      timeouts.autonomy <= gcpr_pkg::AUTONOMY_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        gcpr_pkg::REG_MANUAL_TIMEOUT: begin
          timeouts.manual <= pwdata[gcpr_pkg::TIMEOUT_W-1:0];
        end
        gcpr_pkg::REG_VOICE_TIMEOUT: begin
          timeouts.voice <= pwdata[gcpr_pkg::TIMEOUT_W-1:0];
        end
        gcpr_pkg::REG_AUTONOMY_TIMEOUT: begin
          timeouts.autonomy <= pwdata[gcpr_pkg::TIMEOUT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      gcpr_pkg::REG_MANUAL_TIMEOUT: begin
        prdata = gcpr_pkg::PDATA_W'(timeouts.manual);
      end
      gcpr_pkg::REG_VOICE_TIMEOUT: begin
        prdata = gcpr_pkg::PDATA_W'(timeouts.voice);
      end
      gcpr_pkg::REG_AUTONOMY_TIMEOUT: begin
        prdata = gcpr_pkg::PDATA_W'(timeouts.autonomy);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/gcpr_route.sv
// Source state and routing decision of the gimbal command priority router.
// Keeps stored commands, ages and flags, and works out one result per item; depends on gcpr_pkg.
module gcpr_route #(
  parameter int RATE_WIDTH = 16,
  parameter int AGE_WIDTH  = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  gcpr_pkg::item_ctrl_t          ctrl,
  input  logic signed [RATE_WIDTH-1:0]  yaw_rate_in,
  input  logic signed [RATE_WIDTH-1:0]  pitch_rate_in,
  input  gcpr_pkg::timeouts_t           timeouts,
  output gcpr_pkg::res_ctrl_t           res,
  output logic signed [RATE_WIDTH-1:0]  out_yaw_rate,
  output logic signed [RATE_WIDTH-1:0]  out_pitch_rate
);

  localparam int CMP_W = (AGE_WIDTH > gcpr_pkg::TIMEOUT_W) ? AGE_WIDTH : gcpr_pkg::TIMEOUT_W;
  localparam int NS    = gcpr_pkg::NUM_SRC;

  logic signed [RATE_WIDTH-1:0] cmd_yaw        [NS];
  logic signed [RATE_WIDTH-1:0] cmd_yaw_next   [NS];
  logic signed [RATE_WIDTH-1:0] cmd_pitch      [NS];
  logic signed [RATE_WIDTH-1:0] cmd_pitch_next [NS];
  logic [NS-1:0]                cmd_yaw_hold;
  logic [NS-1:0]                cmd_yaw_hold_next;
  logic [NS-1:0]                cmd_pitch_hold;
  logic [NS-1:0]                cmd_pitch_hold_next;
  logic [AGE_WIDTH-1:0]         age      [NS];
  logic [AGE_WIDTH-1:0]         age_next [NS];
  logic [NS-1:0]                received;
  logic [NS-1:0]                received_next;
  logic                         estop_flag;
  logic                         estop_flag_next;
  logic                         last_was_stop;
  logic                         last_was_stop_next;

  logic [gcpr_pkg::TIMEOUT_W-1:0] limit [NS];
  logic [NS-1:0]                  fresh;
  logic [1:0]                     sel;
  gcpr_pkg::origin_t              sel_origin;

  assign limit[gcpr_pkg::SRC_MANUAL]   = timeouts.manual;
  assign limit[gcpr_pkg::SRC_VOICE]    = timeouts.voice;
  assign limit[gcpr_pkg::SRC_AUTONOMY] = timeouts.autonomy;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      fresh[i] = received[i] && (CMP_W'(age[i]) <= CMP_W'(limit[i]));
    end
  end

  always_comb begin
    sel        = gcpr_pkg::SRC_MANUAL;
    sel_origin = gcpr_pkg::ORG_MANUAL;
    priority if (fresh[gcpr_pkg::SRC_MANUAL]) begin
      sel        = gcpr_pkg::SRC_MANUAL;
      sel_origin = gcpr_pkg::ORG_MANUAL;
    end else if (fresh[gcpr_pkg::SRC_VOICE]) begin
      sel        = gcpr_pkg::SRC_VOICE;
      sel_origin = gcpr_pkg::ORG_VOICE;
    end else begin
      sel        = gcpr_pkg::SRC_AUTONOMY;
      sel_origin = gcpr_pkg::ORG_AUTONOMY;
    end
  end

  always_comb begin
    cmd_yaw_next        = cmd_yaw;
    cmd_pitch_next      = cmd_pitch;
    cmd_yaw_hold_next   = cmd_yaw_hold;
    cmd_pitch_hold_next = cmd_pitch_hold;
    age_next            = age;
    received_next       = received;
    estop_flag_next     = estop_flag;
    last_was_stop_next  = last_was_stop;
    res                 = '0;
    out_yaw_rate        = '0;
    out_pitch_rate      = '0;
    if (en) begin
      unique case (ctrl.cmd)
        gcpr_pkg::CMD_TICK: begin
          if (estop_flag) begin
            res.publish        = 1'b1;
            res.yaw_hold       = 1'b1;
            res.pitch_hold     = 1'b1;
            res.origin         = gcpr_pkg::ORG_ESTOP;
            last_was_stop_next = 1'b1;
          end else if (|fresh) begin
            res.publish        = 1'b1;
            res.yaw_hold       = cmd_yaw_hold[sel];
            res.pitch_hold     = cmd_pitch_hold[sel];
            res.origin         = sel_origin;
            out_yaw_rate       = cmd_yaw[sel];
            out_pitch_rate     = cmd_pitch[sel];
            last_was_stop_next = cmd_yaw_hold[sel] && cmd_pitch_hold[sel];
          end else if (!last_was_stop) begin
            res.publish        = 1'b1;
            res.yaw_hold       = 1'b1;
            res.pitch_hold     = 1'b1;
            res.origin         = gcpr_pkg::ORG_IDLE;
            last_was_stop_next = 1'b1;
          end
          for (int i = 0; i < NS; i++) begin
            if (age[i] != {AGE_WIDTH{1'b1}}) begin
              age_next[i] = age[i] + AGE_WIDTH'(1);
            end
          end
        end
        gcpr_pkg::CMD_ARRIVE: begin
          if (ctrl.source_id != gcpr_pkg::SRC_NONE) begin
            cmd_yaw_next[ctrl.source_id]        = yaw_rate_in;
            cmd_pitch_next[ctrl.source_id]      = pitch_rate_in;
            cmd_yaw_hold_next[ctrl.source_id]   = ctrl.yaw_hold;
            cmd_pitch_hold_next[ctrl.source_id] = ctrl.pitch_hold;
            age_next[ctrl.source_id]            = '0;
            received_next[ctrl.source_id]       = 1'b1;
          end
        end
        gcpr_pkg::CMD_ESTOP: begin
          estop_flag_next = ctrl.estop_level;
        end
        gcpr_pkg::CMD_HOME: begin
          priority if (estop_flag) begin
            res.home_status = gcpr_pkg::HOME_REJ_ESTOP;
          end else if (fresh[gcpr_pkg::SRC_MANUAL]) begin
            res.home_status = gcpr_pkg::HOME_REJ_MANUAL;
          end else if (!ctrl.driver_ready) begin
            res.home_status = gcpr_pkg::HOME_REJ_DRIVER;
          end else begin
            cmd_yaw_next[gcpr_pkg::SRC_VOICE]        = '0;
            cmd_pitch_next[gcpr_pkg::SRC_VOICE]      = '0;
            cmd_yaw_hold_next[gcpr_pkg::SRC_VOICE]   = 1'b1;
            cmd_pitch_hold_next[gcpr_pkg::SRC_VOICE] = 1'b1;
            age_next[gcpr_pkg::SRC_VOICE]            = '0;
            received_next[gcpr_pkg::SRC_VOICE]       = 1'b1;
            res.publish        = 1'b1;
            res.yaw_hold       = 1'b1;
            res.pitch_hold     = 1'b1;
            res.origin         = gcpr_pkg::ORG_HOME;
            res.home_status    = gcpr_pkg::HOME_ACCEPTED;
            res.forward_home   = 1'b1;
            last_was_stop_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmd_yaw        <= cmd_yaw_next;
    cmd_pitch      <= cmd_pitch_next;
    cmd_yaw_hold   <= cmd_yaw_hold_next;
    cmd_pitch_hold <= cmd_pitch_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        age[i] <= '0;
      end
      received      <= '0;
      estop_flag    <= 1'b0;
      last_was_stop <= 1'b1;
    end else begin
      age           <= age_next;
      received      <= received_next;
      estop_flag    <= estop_flag_next;
      last_was_stop <= last_was_stop_next;
    end
  end

`ifndef SYNTH
  a_fwd_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    res.forward_home |-> (res.home_status == gcpr_pkg::HOME_ACCEPTED) && res.publish)
    else $error("home forwarded without an accepted request");

  a_home_resets_voice: assert property (@(posedge clk) disable iff (rst)
    en && res.forward_home |=> received[gcpr_pkg::SRC_VOICE] && (age[gcpr_pkg::SRC_VOICE] == '0))
    else $error("accepted home did not refresh the voice source");

  a_estop_tick_stops: assert property (@(posedge clk) disable iff (rst)
    en && (ctrl.cmd == gcpr_pkg::CMD_TICK) && estop_flag |=> last_was_stop)
    else $error("tick under e-stop did not record a stop");

  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    !res.publish |-> (res.origin == gcpr_pkg::ORG_ESTOP) && (out_yaw_rate == '0) &&
                     (out_pitch_rate == '0) && !res.yaw_hold && !res.pitch_hold)
    else $error("unpublished result carries command fields");
`endif

endmodule

// File: rtl/core/gimbal_command_priority_router_core.sv
// Top level of the gimbal command priority router.
// Holds the input and result registers of the stream channels; uses gcpr_cfg_regs, gcpr_route
// and gcpr_pkg.
//
// The slave channel takes one event per transaction: s_tuser gives the operation (routing
// tick, command arrival, e-stop update, home request) and s_tdata its fields. Every event
// gives exactly one result transaction on the master channel; m_tuser says whether a command
// is published and where it came from, m_tdata holds the command and the home status.
// An event passes an input register and the routing logic into the result register, from
// which its result is offered on the master channel. One event is taken in every cycle while
// the master side keeps up; the routing state is updated at the same clock edge that loads an
// event's result into the result register, so consecutive events see each other without gaps.
// When the receiver stalls, the result register holds and the input register fills; the slave
// side stops taking events only when both are occupied, and nothing is lost.
// Reset clears the source flags and ages, releases the e-stop, marks the last output as a stop
// and loads the default timeouts of 17, 40 and 12 ticks. The user writes the timeouts through
// the APB port only while the block is idle; the block itself does not enforce this.
module gimbal_command_priority_router_core #(
  parameter int RATE_WIDTH = 16,
  parameter int AGE_WIDTH  = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // source_id[1:0], yaw_rate_in, pitch_rate_in, hold_yaw_in, hold_pitch_in, estop_level,
  // driver_ready, zero fill
  input  logic [((2*RATE_WIDTH+6+7)/8)*8-1:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_yaw_rate, out_pitch_rate, out_hold_yaw, out_hold_pitch, home_status[2:0],
  // forward_home, zero fill
  output logic [((2*RATE_WIDTH+6+7)/8)*8-1:0] m_tdata,
  // publish, out_origin[2:0]
  output logic [3:0]                        m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gcpr_pkg::ADDR_W-1:0]       paddr,
  input  logic [gcpr_pkg::PDATA_W-1:0]      pwdata,
  output logic [gcpr_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int DATA_W = ((2*RATE_WIDTH+6+7)/8)*8;

  logic                  in_valid;
  logic [DATA_W-1:0]     in_data;
  logic [1:0]            in_user;
  logic                  out_load;
  logic                  advance;

  gcpr_pkg::item_ctrl_t         ctrl;
  logic signed [RATE_WIDTH-1:0] yaw_in;
  logic signed [RATE_WIDTH-1:0] pitch_in;
  gcpr_pkg::timeouts_t          timeouts;
  gcpr_pkg::res_ctrl_t          res;
  logic signed [RATE_WIDTH-1:0] res_yaw;
  logic signed [RATE_WIDTH-1:0] res_pitch;

  assign out_load = !m_tvalid || m_tready;
  assign advance  = in_valid && out_load;
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_user <= s_tuser;
    end
  end

  assign ctrl.cmd          = gcpr_pkg::cmd_t'(in_user);
  assign ctrl.source_id    = in_data[1:0];
  assign yaw_in            = in_data[2 +: RATE_WIDTH];
  assign pitch_in          = in_data[2+RATE_WIDTH +: RATE_WIDTH];
  assign ctrl.yaw_hold     = in_data[2+2*RATE_WIDTH];
  assign ctrl.pitch_hold   = in_data[3+2*RATE_WIDTH];
  assign ctrl.estop_level  = in_data[4+2*RATE_WIDTH];
  assign ctrl.driver_ready = in_data[5+2*RATE_WIDTH];

  gcpr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .timeouts (timeouts)
  );

  gcpr_route #(
    .RATE_WIDTH (RATE_WIDTH),
    .AGE_WIDTH  (AGE_WIDTH)
  ) u_route (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .ctrl           (ctrl),
    .yaw_rate_in    (yaw_in),
    .pitch_rate_in  (pitch_in),
    .timeouts       (timeouts),
    .res            (res),
    .out_yaw_rate   (res_yaw),
    .out_pitch_rate (res_pitch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= DATA_W'({res.forward_home, res.home_status, res.pitch_hold, res.yaw_hold,
                          res_pitch, res_yaw});
      m_tuser <= {res.origin, res.publish};
    end
  end

endmodule
